// ===== design/ssim_pkg.sv =====
package ssim_pkg;

  localparam int IN_W    = 25;
  localparam int OUT_FRAC = 22;
  localparam int SSIM_W  = 24;
  localparam int SUM_W   = 64;
  localparam int FACT_W  = 64;
  localparam int PROD_W  = 128;
  localparam int QCNT_W  = 5;

  localparam logic [0:0] REG_C1 = 1'b0;
  localparam logic [0:0] REG_C2 = 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_FACT = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_CMP  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  typedef struct packed {
    logic load;
    logic fact;
    logic mul_step;
    logic cmp;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic early;
  } stat_t;

endpackage

// ===== design/ssim_dp.sv =====
module ssim_dp #(
  parameter int FRAC_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ssim_pkg::cmd_t                cmd,
  output ssim_pkg::stat_t               stat,
  input  logic [ssim_pkg::IN_W-1:0]     c1,
  input  logic [ssim_pkg::IN_W-1:0]     c2,
  input  logic [5*ssim_pkg::IN_W:0]     in_word,
  output logic signed [ssim_pkg::SSIM_W-1:0] ssim_value,
  output logic [ssim_pkg::SUM_W-1:0]    tile_sum,
  output logic                          sum_done
);
  localparam int W = ssim_pkg::IN_W;
  localparam int F = ssim_pkg::FACT_W;
  localparam int P = ssim_pkg::PROD_W;

  logic [W-1:0] ma_r, mb_r, sa_r, sb_r, sp_r;
  logic         last_r;
  logic [F-1:0] n1_r, n2_r, d1_r, d2_r;
  logic         neg_r;
  logic [1:0]   mstep_r;
  logic [P-1:0] num_r, den_r, rem_r;
  logic [ssim_pkg::OUT_FRAC:0] q_r;
  logic [ssim_pkg::QCNT_W-1:0] cnt_r;
  logic [ssim_pkg::SUM_W-1:0] run_r;

  logic [F-1:0] a2, b2, ab, cc1, cc2, sa_s, sb_s, sp_s, n1, n2, d1, d2;
  logic [2*W-1:0] a2w, b2w, abw;
  logic [31:0] mul_a, mul_b;
  logic [F-1:0] pp;
  logic [P-1:0] rem_sh;

  // 25x25 products, exact at 50 bits, formed in the fact state
  assign a2w = (2*W)'(ma_r) * (2*W)'(ma_r);
  assign b2w = (2*W)'(mb_r) * (2*W)'(mb_r);
  assign abw = (2*W)'(ma_r) * (2*W)'(mb_r);
  assign a2 = F'(a2w);
  assign b2 = F'(b2w);
  assign ab = F'(abw);
  assign cc1 = F'(c1) << FRAC_BITS;
  assign cc2 = F'(c2) << FRAC_BITS;
  assign sa_s = F'(sa_r) << FRAC_BITS;
  assign sb_s = F'(sb_r) << FRAC_BITS;
  assign sp_s = F'(sp_r) << FRAC_BITS;
  assign n1 = (ab << 1) + cc1;
  assign n2 = ((sp_s - ab) << 1) + cc2;
  assign d1 = a2 + b2 + cc1;
  assign d2 = (sa_s - a2) + (sb_s - b2) + cc2;

  function automatic logic [F-1:0] absv(input logic [F-1:0] v);
    absv = v[F-1] ? (~v + F'(1)) : v;
  endfunction

  // 64x64 products in 32x32 partials, four steps: mstep selects partial
  always_comb begin
    unique case (mstep_r)
      2'd0: begin mul_a = n1_r[31:0];  mul_b = n2_r[31:0];  end
      2'd1: begin mul_a = n1_r[63:32]; mul_b = n2_r[31:0];  end
      2'd2: begin mul_a = n1_r[31:0];  mul_b = n2_r[63:32]; end
      default: begin mul_a = n1_r[63:32]; mul_b = n2_r[63:32]; end
    endcase
  end
  assign pp = F'(mul_a) * F'(mul_b);
  logic [31:0] dul_a, dul_b;
  logic [F-1:0] dp;
  always_comb begin
    unique case (mstep_r)
      2'd0: begin dul_a = d1_r[31:0];  dul_b = d2_r[31:0];  end
      2'd1: begin dul_a = d1_r[63:32]; dul_b = d2_r[31:0];  end
      2'd2: begin dul_a = d1_r[31:0];  dul_b = d2_r[63:32]; end
      default: begin dul_a = d1_r[63:32]; dul_b = d2_r[63:32]; end
    endcase
  end
  assign dp = F'(dul_a) * F'(dul_b);
  logic [6:0] sh;
  assign sh = (mstep_r == 2'd0) ? 7'd0 : (mstep_r == 2'd3) ? 7'd64 : 7'd32;

  assign rem_sh = rem_r << 1;
  assign stat.mul_done = (mstep_r == 2'd3);
  assign stat.div_done = (cnt_r == ssim_pkg::QCNT_W'(ssim_pkg::OUT_FRAC - 1));
  assign stat.early = (den_r == '0) || (num_r >= den_r);

  logic signed [ssim_pkg::SSIM_W-1:0] sv;
  assign sv = neg_r ? -ssim_pkg::SSIM_W'(q_r) : ssim_pkg::SSIM_W'(q_r);

  logic [ssim_pkg::SUM_W-1:0] sum_new;
  assign sum_new = run_r + {{(ssim_pkg::SUM_W-ssim_pkg::SSIM_W){sv[ssim_pkg::SSIM_W-1]}}, sv};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
    end else if (cmd.emit) begin
      run_r <= last_r ? '0 : sum_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      {last_r, sp_r, sb_r, sa_r, mb_r, ma_r} <= in_word;
    end
    if (cmd.fact) begin
      n1_r <= absv(n1);
      n2_r <= absv(n2);
      d1_r <= absv(d1);
      d2_r <= absv(d2);
      neg_r <= n1[F-1] ^ n2[F-1] ^ d1[F-1] ^ d2[F-1];
      mstep_r <= 2'd0;
      num_r <= '0;
      den_r <= '0;
    end
    if (cmd.mul_step) begin
      num_r <= num_r + (P'(pp) << sh);
      den_r <= den_r + (P'(dp) << sh);
      mstep_r <= mstep_r + 2'd1;
    end
    if (cmd.cmp) begin
      rem_r <= num_r;
      cnt_r <= '0;
      q_r <= (den_r == '0) ? '0 :
             (num_r >= den_r) ? {1'b1, {ssim_pkg::OUT_FRAC{1'b0}}} : '0;
    end
    if (cmd.div_step) begin
      cnt_r <= cnt_r + 1'b1;
      if (rem_sh >= den_r) begin
        rem_r <= rem_sh - den_r;
        q_r <= {q_r[ssim_pkg::OUT_FRAC-1:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        q_r <= {q_r[ssim_pkg::OUT_FRAC-1:0], 1'b0};
      end
    end
    if (cmd.emit) begin
      ssim_value <= sv;
      tile_sum <= sum_new;
      sum_done <= last_r;
    end
  end
endmodule

// ===== design/ssim_ctrl.sv =====
module ssim_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_fire,
  input  logic             out_free,
  input  ssim_pkg::stat_t  stat,
  output ssim_pkg::cmd_t   cmd,
  output logic             busy
);
  ssim_pkg::state_t st_r, st_nxt;

  always_comb begin
    st_nxt = st_r;
    cmd = '0;
    cmd.load = in_fire;
    unique case (st_r)
      ssim_pkg::ST_IDLE: if (in_fire) st_nxt = ssim_pkg::ST_FACT;
      ssim_pkg::ST_FACT: begin cmd.fact = 1'b1; st_nxt = ssim_pkg::ST_MUL; end
      ssim_pkg::ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (stat.mul_done) st_nxt = ssim_pkg::ST_CMP;
      end
      ssim_pkg::ST_CMP: begin
        cmd.cmp = 1'b1;
        st_nxt = stat.early ? ssim_pkg::ST_OUT : ssim_pkg::ST_DIV;
      end
      ssim_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) st_nxt = ssim_pkg::ST_OUT;
      end
      ssim_pkg::ST_OUT: if (out_free) begin
        cmd.emit = 1'b1;
        st_nxt = ssim_pkg::ST_IDLE;
      end
      default: st_nxt = ssim_pkg::ST_IDLE;
    endcase
  end

  assign busy = (st_r != ssim_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ssim_pkg::ST_IDLE;
    else        st_r <= st_nxt;
  end
endmodule

// ===== design/ssim_map_and_tile_sum.sv =====
// Channel | dir | tdata (low bit up)                              | tuser | tlast
// in_     | in  | mean_a, mean_b, mean_sq_a, mean_sq_b, mean_prod | -     | tile_end
// out_    | out | ssim_value, tile_sum                            | -     | sum_done
// cfg_    | in  | index 0 stab_c1, index 1 stab_c2                | -     | -
//
// A word passes through load, factor, 4 partial-product steps of the 32x32
// multipliers, compare, 22 steps of the restoring divider and emit when the
// ratio is below one; the divider is skipped when it saturates or the divisor is 0.
// The output register holds a result until taken; the emit waits for it to
// empty, and the next word is accepted the cycle after the emit.
// Reset is synchronous, active low.
module ssim_map_and_tile_sum #(
  parameter int FRAC_BITS = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,  // mean_a, mean_b, mean_sq_a, mean_sq_b, mean_prod
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [87:0]  out_tdata, // ssim_value[23:0], tile_sum[87:24]
  output logic         out_tlast,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [24:0]  cfg_data
);
  ssim_pkg::cmd_t  cmd;
  ssim_pkg::stat_t stat;
  logic busy, ov_r, in_fire, out_free;
  logic [24:0] c1_r, c2_r;
  logic signed [23:0] sv;
  logic [63:0] ts;

  assign in_tready = !busy;
  assign in_fire = in_tvalid && in_tready;
  assign out_free = !ov_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= 25'd1678;
      c2_r <= 25'd15099;
      ov_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == ssim_pkg::REG_C1) c1_r <= cfg_data;
      if (cfg_we && cfg_index == ssim_pkg::REG_C2) c2_r <= cfg_data;
      if (cmd.emit) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
  end

  ssim_ctrl u_ctrl (.clk, .rst_n, .in_fire, .out_free, .stat, .cmd, .busy);

  ssim_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst_n, .cmd, .stat, .c1(c1_r), .c2(c2_r),
    .in_word({in_tlast, in_tdata[124:0]}),
    .ssim_value(sv), .tile_sum(ts), .sum_done(out_tlast)
  );

  assign out_tvalid = ov_r;
  assign out_tdata = {ts, sv};
endmodule

// ===== design/ssim_chk.sv =====
module ssim_chk (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [87:0] out_tdata,
  input logic out_tlast
);
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[23:0]) <= 24'sd4194304 &&
                    $signed(out_tdata[23:0]) >= -24'sd4194304))
    else $error("ssim out of range");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted two words back to back");
endmodule

bind ssim_map_and_tile_sum ssim_chk u_chk (.*);
